// ----- rtl/b2d_pkg.sv -----
// Shared constants, types and helpers for the binary to decimal ASCII converter.
package b2d_pkg;

    localparam int DEF_VALUE_BITS = 31;
    localparam int DIGIT_BITS     = 4;
    localparam int CHAR_BITS      = 6;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'h30;

    typedef logic [DIGIT_BITS-1:0] digit_t;
    typedef logic [CHAR_BITS-1:0]  char_t;

    // Conversion status (the done flag) handed from the shift-add unit to the serializer.
    typedef struct packed {
        logic done;
    } cvt_status_t;

    // Decimal digits of 2^bits - 1: floor(bits * log10(2)) + 1, log10(2) ~ 1233/4096.
    function automatic int num_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

// ----- rtl/b2d_dabble.sv -----
// Shift-and-add-3 binary to BCD unit, one input bit per cycle.
module b2d_dabble #(
    parameter int VALUE_BITS = b2d_pkg::DEF_VALUE_BITS,
    parameter int NUM_DIGITS = b2d_pkg::num_digits(b2d_pkg::DEF_VALUE_BITS)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  logic [VALUE_BITS-1:0]                  value,
    output logic                                   busy,
    output b2d_pkg::cvt_status_t                   status,
    output logic [NUM_DIGITS*b2d_pkg::DIGIT_BITS-1:0] bcd
);

    localparam int BCD_W = NUM_DIGITS * b2d_pkg::DIGIT_BITS;
    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [BCD_W-1:0]      bcd_reg, bcd_next, bcd_adj;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Digits of 5 or more get +3 so the next left shift carries correctly.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*b2d_pkg::DIGIT_BITS +: b2d_pkg::DIGIT_BITS] >= 4'd5)
                bcd_adj[i*b2d_pkg::DIGIT_BITS +: b2d_pkg::DIGIT_BITS] =
                    bcd_reg[i*b2d_pkg::DIGIT_BITS +: b2d_pkg::DIGIT_BITS] + 4'd3;
            else
                bcd_adj[i*b2d_pkg::DIGIT_BITS +: b2d_pkg::DIGIT_BITS] =
                    bcd_reg[i*b2d_pkg::DIGIT_BITS +: b2d_pkg::DIGIT_BITS];
        end
        bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VALUE_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    assign busy        = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

// ----- rtl/b2d_emit.sv -----
// Digit serializer: shifts BCD out MSD first, drops leading zeros, flags the last digit.
module b2d_emit #(
    parameter int NUM_DIGITS = b2d_pkg::num_digits(b2d_pkg::DEF_VALUE_BITS)
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  b2d_pkg::cvt_status_t                      status,
    input  logic [NUM_DIGITS*b2d_pkg::DIGIT_BITS-1:0] bcd,
    output logic                                      busy,
    output logic                                      digit_strobe,
    output b2d_pkg::char_t                            digit_char,
    output logic                                      last_digit
);

    localparam int BCD_W = NUM_DIGITS * b2d_pkg::DIGIT_BITS;
    localparam int POS_W = $clog2(NUM_DIGITS + 1);

    logic [BCD_W-1:0]  digits_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              active_reg;
    logic              lead_reg;
    logic              strobe_reg;
    b2d_pkg::char_t    char_reg;
    logic              last_reg;

    b2d_pkg::digit_t   top;
    logic              is_last;
    logic              emit;

    assign top     = digits_reg[BCD_W-1 -: b2d_pkg::DIGIT_BITS];
    assign is_last = (pos_reg == POS_W'(1));
    // Units digit always goes out, so zero still yields one word.
    assign emit    = active_reg && (!lead_reg || top != '0 || is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            lead_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            strobe_reg <= emit;
            if (status.done)
            begin
                active_reg <= 1'b1;
                lead_reg   <= 1'b1;
                pos_reg    <= POS_W'(NUM_DIGITS);
            end
            else if (active_reg)
            begin
                pos_reg <= pos_reg - 1'b1;
                if (emit)
                    lead_reg <= 1'b0;
                if (is_last)
                    active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
            digits_reg <= bcd;
        else if (active_reg)
            digits_reg <= {digits_reg[BCD_W-b2d_pkg::DIGIT_BITS-1:0],
                           {b2d_pkg::DIGIT_BITS{1'b0}}};
        if (active_reg)
        begin
            char_reg <= b2d_pkg::ASCII_ZERO | {2'b00, top};
            last_reg <= is_last;
        end
    end

    assign busy         = active_reg;
    assign digit_strobe = strobe_reg;
    assign digit_char   = char_reg;
    assign last_digit   = strobe_reg & last_reg;

endmodule

// ----- rtl/binary_to_decimal_ascii.sv -----
// Top level of the binary to decimal ASCII converter.
// Pulse start with busy low to load value; the block then shifts the value into a BCD
// register one bit per cycle, and serializes the digits one per cycle from the most
// significant position (leading zeros dropped silently). Each digit word appears for
// one cycle with digit_strobe high, and the final word has last_digit set; the receiver
// must take every word as it comes. busy stays high for each value through the
// bit-serial shift-add loop followed by the digit shift-out.
module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = b2d_pkg::DEF_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  digit_strobe,
    output logic [5:0]            digit_char,
    output logic                  last_digit
);

    localparam int NUM_DIGITS = b2d_pkg::num_digits(VALUE_BITS);
    localparam int BCD_W      = NUM_DIGITS * b2d_pkg::DIGIT_BITS;

    logic                 load;
    logic                 cvt_busy;
    logic                 emit_busy;
    b2d_pkg::cvt_status_t status;
    logic [BCD_W-1:0]     bcd;

    // Hand-off cycle between the two units counts as busy too.
    assign busy = cvt_busy | status.done | emit_busy;
    assign load = start & ~busy;

    b2d_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .value  (value),
        .busy   (cvt_busy),
        .status (status),
        .bcd    (bcd)
    );

    b2d_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .bcd          (bcd),
        .busy         (emit_busy),
        .digit_strobe (digit_strobe),
        .digit_char   (digit_char),
        .last_digit   (last_digit)
    );

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy)
        else $error("busy not raised after load");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> !emit_busy)
        else $error("conversion finished while serializer still active");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_strobe && last_digit) |=> !digit_strobe)
        else $error("word follows the last digit");

    a_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cvt_busy |-> !digit_strobe || $past(emit_busy))
        else $error("word without serializer activity");

endmodule

// ----- tb/sv/binary_to_decimal_ascii_test.sv -----
// Testbench for the binary to decimal ASCII converter: directed and random values, scoreboard check.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_test;

    localparam int VALUE_BITS = b2d_pkg::DEF_VALUE_BITS;
    localparam longint VALUE_MAX = (longint'(1) << VALUE_BITS) - 1;
    localparam int RANDOM_VALUES = 430;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        b2d_pkg::char_t ch;
        logic           last;
    } digit_word_t;

    class digit_scoreboard;
        digit_word_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Decimal digits of an accepted value, most significant first.
        function void note_value(input logic [VALUE_BITS-1:0] v);
            b2d_pkg::char_t rev[$];
            logic [VALUE_BITS-1:0] rest;
            digit_word_t w;
            rest = v;
            do begin
                rev.push_back(b2d_pkg::ASCII_ZERO + b2d_pkg::char_t'(rest % 10));
                rest = rest / 10;
            end while (rest != 0);
            for (int k = rev.size() - 1; k >= 0; k--)
            begin
                w.ch = rev[k];
                w.last = (k == 0);
                pending.push_back(w);
            end
        endfunction

        task check_digit(input b2d_pkg::char_t ch, input logic last);
            digit_word_t w;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word char=%0d last=%0b", ch, last));
            end
            else
            begin
                w = pending.pop_front();
                if (ch !== w.ch)
                    report_mismatch($sformatf("digit_char %0d, expected %0d", ch, w.ch));
                if (last !== w.last)
                    report_mismatch($sformatf("last_digit %0b, expected %0b", last, w.last));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_BITS-1:0] value;
    logic                  digit_strobe;
    logic [5:0]            digit_char;
    logic                  last_digit;

    digit_scoreboard sb;

    binary_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .digit_strobe(digit_strobe),
        .digit_char(digit_char),
        .last_digit(last_digit)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && digit_strobe)
            sb.check_digit(digit_char, last_digit);
    end

    // Idle length before a value: mostly none, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        else if (r < 17)
            return $urandom_range(1, 4);
        else if (r < 19)
            return $urandom_range(5, 40);
        return $urandom_range(41, 120);
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        longint lo;
        longint hi;
        int n;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return VALUE_BITS'($urandom());
        if (r < 7)
        begin
            // uniform over a random digit count
            n = $urandom_range(1, 10);
            lo = (n == 1) ? 0 : 1;
            hi = 1;
            for (int k = 1; k < n; k++)
                lo = lo * 10;
            for (int k = 0; k < n; k++)
                hi = hi * 10;
            hi = hi - 1;
            if (hi > VALUE_MAX)
                hi = VALUE_MAX;
            return VALUE_BITS'($urandom_range(int'(hi), int'(lo)));
        end
        if (r == 7)
            return VALUE_BITS'(longint'(1) << $urandom_range(0, VALUE_BITS - 1));
        if (r == 8)
            return VALUE_BITS'((longint'(1) << $urandom_range(1, VALUE_BITS)) - 1);
        // next to a power of ten
        n = $urandom_range(1, 9);
        hi = 1;
        for (int k = 0; k < n; k++)
            hi = hi * 10;
        hi = hi + $urandom_range(0, 6) - 3;
        return VALUE_BITS'(hi);
    endfunction

    task send_value(input logic [VALUE_BITS-1:0] v, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            value <= VALUE_BITS'($urandom());
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_value(v);
    endtask

    task wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    logic [VALUE_BITS-1:0] directed[] = '{
        0, 1, 9, 10, 99, 100, 999, 1000, 99999, 100000, 9999999, 10000000,
        999999999, 1000000000, 1234567890, 2147483646, 2147483647,
        1431655765, 715827882, 1073741824
    };

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_value(directed[i], (i % 4 == 3) ? 3 : 0);

        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            if (i == RANDOM_VALUES / 2)
            begin
                @(negedge clk);
                start <= 1'b0;
                wait_drained();
                repeat (45) @(posedge clk);
            end
            send_value(pick_value(), pick_gap());
        end
        @(negedge clk);
        start <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
